### rtl/core/alle_pkg.sv
package alle_pkg;

  localparam int SLOT_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int SLOTS    = 256;
  localparam int CAPACITY = SLOTS - 1;
  localparam int PV_W     = SLOT_W + 1;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] CAP_SLOTS = SLOT_W'(CAPACITY);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ELEM = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_INS,
    S_INS2,
    S_DEL2,
    S_DONE
  } state_t;

  // next-link memory port
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] wa;
    logic [SLOT_W-1:0] wd;
    logic [SLOT_W-1:0] ra;
  } nx_req_t;

  // {in_use, prev} memory port
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] wa;
    logic [PV_W-1:0]   wd;
    logic [SLOT_W-1:0] ra;
  } pv_req_t;

  // value memory write port
  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  wa;
    logic [VALUE_W-1:0] wd;
  } val_req_t;

endpackage

### rtl/core/alle_ram.sv
module alle_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/alle_ctrl.sv
module alle_ctrl import alle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [SLOT_W-1:0]  slot_index,
  input  logic [VALUE_W-1:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SLOT_W-1:0]  new_slot,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  head_slot,
  output logic [SLOT_W-1:0]  tail_slot,
  output logic [SLOT_W-1:0]  count,
  output nx_req_t            nx_req,
  input  logic [SLOT_W-1:0]  nx_rd,
  output pv_req_t            pv_req,
  input  logic [PV_W-1:0]    pv_rd,
  output val_req_t           val_req
);

  state_t             state, state_next;
  logic               op_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [VALUE_W-1:0] val_q;
  logic [SLOT_W-1:0]  after;
  logic [SLOT_W-1:0]  res_slot;
  logic [1:0]         res_status;
  logic [SLOT_W-1:0]  head;
  logic [SLOT_W-1:0]  tail;
  logic [SLOT_W-1:0]  free_head;
  logic [SLOT_W-1:0]  elem_count;
  logic [SLOT_W-1:0]  init_cnt;
  logic               live;
  logic               full;
  logic               out_free;
  logic [SLOT_W-1:0]  rd_prev;

  assign rd_prev  = pv_rd[SLOT_W-1:0];
  assign live     = pv_rd[SLOT_W] && (idx_q != '0);
  assign full     = (elem_count >= CAP_SLOTS) || (free_head == '0);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    nx_req     = '0;
    pv_req     = '0;
    val_req    = '0;
    nx_req.ra  = idx_q;
    pv_req.ra  = idx_q;
    unique case (state)
      S_INIT: begin
        nx_req.we = 1'b1;
        nx_req.wa = init_cnt;
        nx_req.wd = (init_cnt == '0 || init_cnt == LAST_SLOT) ? '0 : init_cnt + 1'b1;
        pv_req.we = 1'b1;
        pv_req.wa = init_cnt;
        pv_req.wd = '0;
        if (init_cnt == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall  = 1'b0;
        nx_req.ra = slot_index;
        pv_req.ra = slot_index;
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (op_q == OP_INSERT) begin
          if ((idx_q != '0 && !live) || full) begin
            state_next = S_DONE;
          end else begin
            nx_req.ra  = free_head;
            state_next = S_INS;
          end
        end else if (!live) begin
          state_next = S_DONE;
        end else begin
          // unlink: next[p] = q, prev[q] = p
          nx_req.we  = 1'b1;
          nx_req.wa  = rd_prev;
          nx_req.wd  = nx_rd;
          pv_req.we  = 1'b1;
          pv_req.wa  = nx_rd;
          pv_req.wd  = {nx_rd != '0, rd_prev};
          state_next = S_DEL2;
        end
      end
      S_INS: begin
        nx_req.we  = 1'b1;
        nx_req.wa  = res_slot;
        nx_req.wd  = after;
        pv_req.we  = 1'b1;
        pv_req.wa  = res_slot;
        pv_req.wd  = {1'b1, idx_q};
        val_req.we = 1'b1;
        val_req.wa = res_slot;
        val_req.wd = val_q;
        state_next = S_INS2;
      end
      S_INS2: begin
        nx_req.we  = 1'b1;
        nx_req.wa  = idx_q;
        nx_req.wd  = res_slot;
        pv_req.we  = 1'b1;
        pv_req.wa  = after;
        pv_req.wd  = {after != '0, res_slot};
        state_next = S_DONE;
      end
      S_DEL2: begin
        nx_req.we  = 1'b1;
        nx_req.wa  = idx_q;
        nx_req.wd  = free_head;
        pv_req.we  = 1'b1;
        pv_req.wa  = idx_q;
        pv_req.wd  = '0;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      head       <= '0;
      tail       <= '0;
      free_head  <= SLOT_W'(1);
      elem_count <= '0;
      init_cnt   <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
        end
        S_READ: begin
          if (op_q == OP_DELETE && live) begin
            if (rd_prev == '0) begin
              head <= nx_rd;
            end
            if (nx_rd == '0) begin
              tail <= rd_prev;
            end
          end
        end
        S_INS: begin
          free_head <= nx_rd;
        end
        S_INS2: begin
          if (idx_q == '0) begin
            head <= res_slot;
          end
          if (after == '0) begin
            tail <= res_slot;
          end
          elem_count <= elem_count + 1'b1;
        end
        S_DEL2: begin
          free_head <= idx_q;
          if (elem_count != '0) begin
            elem_count <= elem_count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_q       <= op;
        idx_q      <= slot_index;
        val_q      <= item_value;
        res_slot   <= '0;
        res_status <= ST_OK;
      end
      S_READ: begin
        after <= nx_rd;
        if (op_q == OP_INSERT) begin
          if (idx_q != '0 && !live) begin
            res_status <= ST_NO_ELEM;
          end else if (full) begin
            res_status <= ST_FULL;
          end else begin
            res_slot <= free_head;
          end
        end else if (!live) begin
          res_status <= ST_NO_ELEM;
        end
      end
      S_DONE: begin
        if (out_free) begin
          new_slot  <= res_slot;
          status    <= res_status;
          head_slot <= head;
          tail_slot <= tail;
          count     <= elem_count;
        end
      end
      default: begin
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CAP_SLOTS)
    else $error("element count above capacity");

  // on insert, free_head advances in the cycle before the count does
  a_free_avail: assert property (@(posedge clk) disable iff (rst)
    (elem_count < CAP_SLOTS && state != S_INS2) |-> (free_head != '0))
    else $error("free chain empty while list not full");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (elem_count == '0 && state != S_READ && state != S_DEL2) |-> (head == '0 && tail == '0))
    else $error("empty list with nonzero head or tail");

  a_ok_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && op_q == OP_INSERT && res_status == ST_OK) |-> (res_slot != '0))
    else $error("successful insert without a slot");

endmodule

### rtl/core/array_linked_list_engine.sv
// channel  | handshake              | fields
// ---------+------------------------+----------------------------------------------
// input    | in_valid / in_stall    | op, slot_index, item_value
// output   | out_valid / out_stall  | new_slot, status, head_slot, tail_slot, count
//
// Insert: read links, read free chain, two link writes, result. Delete: read links and unlink,
// free-chain write, result. Rejected: read links, result. Each link memory has one write port.
// After reset an init sweep over all 256 slots loads the free chain; in_stall is high meanwhile.
// The result sits in an output register; a stall there holds the engine in its result step.
module array_linked_list_engine import alle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [SLOT_W-1:0]  slot_index,
  input  logic [VALUE_W-1:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SLOT_W-1:0]  new_slot,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  head_slot,
  output logic [SLOT_W-1:0]  tail_slot,
  output logic [SLOT_W-1:0]  count
);

  nx_req_t           nx_req;
  pv_req_t           pv_req;
  val_req_t          val_req;
  logic [SLOT_W-1:0] nx_rd;
  logic [PV_W-1:0]   pv_rd;

  alle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .slot_index (slot_index),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .new_slot   (new_slot),
    .status     (status),
    .head_slot  (head_slot),
    .tail_slot  (tail_slot),
    .count      (count),
    .nx_req     (nx_req),
    .nx_rd      (nx_rd),
    .pv_req     (pv_req),
    .pv_rd      (pv_rd),
    .val_req    (val_req)
  );

  alle_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
    .clk     (clk),
    .we      (nx_req.we),
    .wr_addr (nx_req.wa),
    .wr_data (nx_req.wd),
    .rd_addr (nx_req.ra),
    .rd_data (nx_rd)
  );

  alle_ram #(.WIDTH(PV_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk     (clk),
    .we      (pv_req.we),
    .wr_addr (pv_req.wa),
    .wr_data (pv_req.wd),
    .rd_addr (pv_req.ra),
    .rd_data (pv_rd)
  );

  alle_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_value_ram (
    .clk     (clk),
    .we      (val_req.we),
    .wr_addr (val_req.wa),
    .wr_data (val_req.wd),
    .rd_addr (val_req.wa),
    .rd_data ()
  );

endmodule
